// ===== sv/pet_pkg.sv =====
// Shared types, widths and register codes for the Prewitt edge threshold core.
package pet_pkg;

	localparam int PIX_W        = 8;
	localparam int TH_W         = 9;
	localparam int FW_W         = 11;
	localparam int FH_W         = 13;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 13;
	localparam int TH2_W        = 2 * TH_W;
	localparam int GRAD_W       = 11;
	localparam int SQ_W         = 20;
	localparam int MAG_W        = SQ_W + 1;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int OUT_FIFO_DEPTH = 8;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

	localparam logic [TH_W-1:0] THRESHOLD_RST    = 9'd0;
	localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd1024;
	localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd768;

	localparam logic [PIX_W-1:0] EDGE_ON  = 8'd255;
	localparam logic [PIX_W-1:0] EDGE_OFF = 8'd0;

	typedef struct packed {
		logic             last;
		logic [PIX_W-1:0] edge_res;
	} result_t;

endpackage

// ===== sv/prewitt_edge_threshold_core.sv =====
// Streaming 3x3 Prewitt edge detector with a squared-magnitude threshold.
//
// Input channel (s_*): one 8-bit grayscale pixel per item in raster order, tuser
// carries the pad flag. Send (frame_height+1) x (frame_width+1) items per frame;
// the extra column and row are pad items that drain the window.
// Output channel (m_*): tdata is 0 or 255, tlast marks the final pixel of the
// frame. An item at padded position (r,c), r,c >= 1, gives pixel (r-1,c-1).
// Configuration: cfg_we/cfg_idx/cfg_wdata, write only while the block is idle.
//
// Throughput is one item per clock while s_tready is high. From accept to
// m_tvalid the steps are line store read, gradient sums, squares, then
// compare into an 8-entry output queue. The two line stores are RAMs read
// at accept and written back in the next cycle at the same column; consecutive
// items always address different columns, so no forwarding is needed.
// When the receiver stalls, the queue fills and s_tready drops once the
// queue plus the items in flight reach its depth.
// Reset clears counters, window, queue and registers (threshold 0, width
// 1024, height 768); line store contents are not cleared.
module prewitt_edge_threshold_core
	import pet_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [PIX_W-1:0]      s_tdata,   // [7:0] pixel
	input  logic                  s_tuser,   // [0] pad
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [PIX_W-1:0]      m_tdata,   // [7:0] edge_res
	output logic                  m_tlast,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int AW    = $clog2(MAX_WIDTH + 1);
	localparam int QAW   = $clog2(OUT_FIFO_DEPTH);
	localparam int QCW   = $clog2(OUT_FIFO_DEPTH + 1);
	localparam int BUSYW = QCW + 1;

	// configuration
	logic [TH2_W-1:0] th2_q;
	logic [FW_W-1:0]  w_eff_q;
	logic [FH_W-1:0]  h_eff_q;
	logic [FW_W-1:0]  fw_in;
	logic [FH_W-1:0]  fh_in;

	assign fw_in = cfg_wdata[FW_W-1:0];
	assign fh_in = cfg_wdata[FH_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			th2_q   <= TH2_W'(THRESHOLD_RST) * TH2_W'(THRESHOLD_RST);
			w_eff_q <= (32'(FRAME_WIDTH_RST) > MAX_WIDTH) ? FW_W'(MAX_WIDTH) : FRAME_WIDTH_RST;
			h_eff_q <= FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_THRESHOLD: begin
					th2_q <= TH2_W'(cfg_wdata[TH_W-1:0]) * TH2_W'(cfg_wdata[TH_W-1:0]);
				end
				REG_FRAME_WIDTH: begin
					if (fw_in == '0) begin
						w_eff_q <= FW_W'(1);
					end else if (32'(fw_in) > MAX_WIDTH) begin
						w_eff_q <= FW_W'(MAX_WIDTH);
					end else begin
						w_eff_q <= fw_in;
					end
				end
				REG_FRAME_HEIGHT: begin
					h_eff_q <= (fh_in == '0) ? FH_W'(1) : fh_in;
				end
				default: begin
				end
			endcase
		end
	end

	// accept stage
	logic            accept;
	logic [FW_W-1:0] col_q;
	logic [FH_W-1:0] row_q;
	logic [AW-1:0]   idx;
	logic [PIX_W-1:0] v_in;

	assign accept = s_tvalid && s_tready;
	assign idx    = (32'(col_q) > MAX_WIDTH) ? AW'(MAX_WIDTH) : AW'(col_q);
	assign v_in   = (s_tuser || col_q >= w_eff_q || row_q >= h_eff_q) ? '0 : s_tdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_q >= w_eff_q) begin
				col_q <= '0;
				row_q <= (row_q >= h_eff_q) ? '0 : row_q + FH_W'(1);
			end else begin
				col_q <= col_q + FW_W'(1);
			end
		end
	end

	// stage 1: line store data arrives, window and gradients
	logic             v_s1;
	logic             prod_s1;
	logic             last_s1;
	logic             top_en_s1;
	logic             mid_en_s1;
	logic             clr_s1;
	logic [PIX_W-1:0] pix_s1;
	logic [AW-1:0]    idx_s1;
	logic [PIX_W-1:0] up_rd;
	logic [PIX_W-1:0] mid_rd;
	logic [47:0]      win_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prod_s1   <= (row_q >= FH_W'(1)) && (col_q >= FW_W'(1)) &&
			             (row_q <= h_eff_q) && (col_q <= w_eff_q);
			last_s1   <= (row_q == h_eff_q) && (col_q == w_eff_q);
			top_en_s1 <= row_q >= FH_W'(2);
			mid_en_s1 <= row_q >= FH_W'(1);
			clr_s1    <= col_q == '0;
			pix_s1    <= v_in;
			idx_s1    <= idx;
		end
	end

	pet_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH + 1)) u_upper (
		.clk   (clk),
		.we    (v_s1),
		.waddr (idx_s1),
		.wdata (mid_rd),
		.re    (accept),
		.raddr (idx),
		.rdata (up_rd)
	);

	pet_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH + 1)) u_middle (
		.clk   (clk),
		.we    (v_s1),
		.waddr (idx_s1),
		.wdata (pix_s1),
		.re    (accept),
		.raddr (idx),
		.rdata (mid_rd)
	);

	logic [PIX_W-1:0] top, mid;
	logic [47:0]      win_eff;
	logic [PIX_W-1:0] mt, mb, lt, lm, lb;
	logic [9:0]       gx_pos, gx_neg, gy_pos, gy_neg;
	logic signed [GRAD_W-1:0] gx, gy;

	assign top     = top_en_s1 ? up_rd : '0;
	assign mid     = mid_en_s1 ? mid_rd : '0;
	assign win_eff = clr_s1 ? '0 : win_q;
	assign mt      = win_eff[7:0];
	assign mb      = win_eff[23:16];
	assign lt      = win_eff[31:24];
	assign lm      = win_eff[39:32];
	assign lb      = win_eff[47:40];
	assign gx_pos  = 10'(top) + 10'(mid) + 10'(pix_s1);
	assign gx_neg  = 10'(lt) + 10'(lm) + 10'(lb);
	assign gy_pos  = 10'(lb) + 10'(mb) + 10'(pix_s1);
	assign gy_neg  = 10'(lt) + 10'(mt) + 10'(top);
	assign gx      = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
	assign gy      = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (v_s1) begin
			win_q <= {win_eff[23:0], pix_s1, mid, top};
		end
	end

	// stage 2: squares
	logic                     v_s2;
	logic                     last_s2;
	logic signed [GRAD_W-1:0] gx_s2, gy_s2;
	logic signed [2*GRAD_W-1:0] gx_sq, gy_sq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1 && prod_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && prod_s1) begin
			gx_s2   <= gx;
			gy_s2   <= gy;
			last_s2 <= last_s1;
		end
	end

	assign gx_sq = gx_s2 * gx_s2;
	assign gy_sq = gy_s2 * gy_s2;

	// stage 3: sum and compare
	logic             v_s3;
	logic             last_s3;
	logic [SQ_W-1:0]  sqx_s3, sqy_s3;
	logic [MAG_W-1:0] mag2;
	result_t          res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			sqx_s3  <= SQ_W'(gx_sq);
			sqy_s3  <= SQ_W'(gy_sq);
			last_s3 <= last_s2;
		end
	end

	assign mag2         = MAG_W'(sqx_s3) + MAG_W'(sqy_s3);
	assign res.edge_res = (mag2 > MAG_W'(th2_q)) ? EDGE_ON : EDGE_OFF;
	assign res.last     = last_s3;

	// output queue
	result_t         q_mem_q [OUT_FIFO_DEPTH];
	logic [QAW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QCW-1:0]  cnt_q;
	logic            push, pop;
	logic [BUSYW-1:0] busy;

	assign push     = v_s3;
	assign m_tvalid = cnt_q != '0;
	assign pop      = m_tvalid && m_tready;
	assign m_tdata  = q_mem_q[rd_ptr_q].edge_res;
	assign m_tlast  = q_mem_q[rd_ptr_q].last;
	assign busy     = BUSYW'(cnt_q) + BUSYW'(v_s1) + BUSYW'(v_s2) + BUSYW'(v_s3);
	assign s_tready = busy < BUSYW'(OUT_FIFO_DEPTH);

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + QCW'(1);
				2'b01:   cnt_q <= cnt_q - QCW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== sv/pet_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module pet_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1025
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/pet_checker.sv =====
// Port-level checks for the Prewitt edge threshold core, bound to the top level.
module pet_checker
	import pet_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [PIX_W-1:0] m_tdata,
	input logic             m_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output item changed while stalled");

	a_out_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata == EDGE_ON || m_tdata == EDGE_OFF))
		else $error("edge result is neither 0 nor 255");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no output item pending");

	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(m_tvalid) |-> $past(m_tready))
		else $error("output item withdrawn without handshake");

endmodule

bind prewitt_edge_threshold_core pet_checker u_pet_checker (.*);
